/* src/dfr_pkg.sv */
// ---------------------------------------------------------------------------
// dfr_pkg
// Shared types, register indexes and CRC byte-update functions for the
// sync/length/CRC framed packet deframer.
// ---------------------------------------------------------------------------
package dfr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SYNC_VALUE      = 3'd0,
      CSR_HEADER_CRC_POLY = 3'd1,
      CSR_HEADER_CRC_SEED = 3'd2,
      CSR_BODY_CRC_POLY   = 3'd3,
      CSR_BODY_CRC_SEED   = 3'd4
   } csr_index_type;

   localparam logic [7:0]  SYNC_VALUE_RESET      = 8'd170;
   localparam logic [7:0]  HEADER_CRC_POLY_RESET = 8'd55;
   localparam logic [7:0]  HEADER_CRC_SEED_RESET = 8'd66;
   localparam logic [15:0] BODY_CRC_POLY_RESET   = 16'd15717;
   localparam logic [15:0] BODY_CRC_SEED_RESET   = 16'd4919;

   typedef enum logic [2:0] {
      EV_DISCARD  = 3'd0,
      EV_HEADER   = 3'd1,
      EV_BAD_LEN  = 3'd2,
      EV_BAD_HCRC = 3'd3,
      EV_PAYLOAD  = 3'd4,
      EV_CRC_BYTE = 3'd5,
      EV_GOOD     = 3'd6,
      EV_BAD      = 3'd7
   } frame_event_type;

   // header byte count that marks the body phase
   localparam logic [1:0] HDR_IN_BODY = 2'd3;

   typedef struct packed {
      logic [7:0]  sync_value;
      logic [7:0]  header_crc_poly;
      logic [7:0]  header_crc_seed;
      logic [15:0] body_crc_poly;
      logic [15:0] body_crc_seed;
   } cfg_type;

   typedef struct packed {
      frame_event_type frame_event;
      logic [7:0]      data_byte;
      logic [7:0]      payload_index;
      logic [6:0]      payload_length;
   } result_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data,
                                              input logic [15:0] poly);
      logic [15:0] r;
      r = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* src/dfr_csr.sv */
// ---------------------------------------------------------------------------
// dfr_csr
// Configuration registers: sync byte, CRC-8 and CRC-16 polynomials and seeds.
// ---------------------------------------------------------------------------
module dfr_csr import dfr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_VALUE:      cfg_in.sync_value      = csr_write_data[7:0];
            CSR_HEADER_CRC_POLY: cfg_in.header_crc_poly = csr_write_data[7:0];
            CSR_HEADER_CRC_SEED: cfg_in.header_crc_seed = csr_write_data[7:0];
            CSR_BODY_CRC_POLY:   cfg_in.body_crc_poly   = csr_write_data;
            CSR_BODY_CRC_SEED:   cfg_in.body_crc_seed   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value      <= SYNC_VALUE_RESET;
         cfg_ff.header_crc_poly <= HEADER_CRC_POLY_RESET;
         cfg_ff.header_crc_seed <= HEADER_CRC_SEED_RESET;
         cfg_ff.body_crc_poly   <= BODY_CRC_POLY_RESET;
         cfg_ff.body_crc_seed   <= BODY_CRC_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/dfr_core.sv */
// ---------------------------------------------------------------------------
// dfr_core
// Frame tracking state and per-byte event decision, including the bytewise
// CRC-8 header check and CRC-16 body check.
// ---------------------------------------------------------------------------
module dfr_core import dfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   logic [1:0]  header_count_ff, header_count_in;
   logic [6:0]  frame_length_ff, frame_length_in;
   logic [7:0]  body_count_ff, body_count_in;
   logic [7:0]  header_crc_ff, header_crc_in;
   logic [15:0] body_crc_ff, body_crc_in;

   logic [7:0]  hcrc_base;
   logic [7:0]  hcrc_next;
   logic [15:0] bcrc_next;
   logic [8:0]  last_crc_index;

   assign hcrc_base      = (header_count_ff == 2'd0) ? cfg.header_crc_seed : header_crc_ff;
   assign hcrc_next      = crc8_byte(hcrc_base, rx_byte, cfg.header_crc_poly);
   assign bcrc_next      = crc16_byte(body_crc_ff, rx_byte, cfg.body_crc_poly);
   assign last_crc_index = {2'b00, frame_length_ff} + 9'd1;

   always_comb begin
      header_count_in       = header_count_ff;
      frame_length_in       = frame_length_ff;
      body_count_in         = body_count_ff;
      header_crc_in         = header_crc_ff;
      body_crc_in           = body_crc_ff;
      result.frame_event    = EV_DISCARD;
      result.data_byte      = rx_byte;
      result.payload_index  = 8'd0;
      result.payload_length = 7'd0;
      case (header_count_ff)
         2'd0: begin
            if (rx_byte == cfg.sync_value) begin
               header_crc_in      = hcrc_next;
               header_count_in    = 2'd1;
               result.frame_event = EV_HEADER;
            end
         end
         2'd1: begin
            if (rx_byte[7]) begin
               header_count_in    = 2'd0;
               frame_length_in    = 7'd0;
               result.frame_event = EV_BAD_LEN;
            end else begin
               header_crc_in      = hcrc_next;
               frame_length_in    = rx_byte[6:0];
               header_count_in    = 2'd2;
               result.frame_event = EV_HEADER;
            end
         end
         2'd2: begin
            header_crc_in = hcrc_next;
            if (hcrc_next != 8'd0) begin
               header_count_in    = 2'd0;
               frame_length_in    = 7'd0;
               result.frame_event = EV_BAD_HCRC;
            end else begin
               header_count_in    = HDR_IN_BODY;
               body_count_in      = 8'd0;
               body_crc_in        = cfg.body_crc_seed;
               result.frame_event = EV_HEADER;
            end
         end
         default: begin
            result.payload_index  = body_count_ff;
            result.payload_length = frame_length_ff;
            body_crc_in           = bcrc_next;
            body_count_in         = body_count_ff + 8'd1;
            if (body_count_ff < {1'b0, frame_length_ff}) begin
               result.frame_event = EV_PAYLOAD;
            end else if ({1'b0, body_count_ff} < last_crc_index) begin
               result.frame_event = EV_CRC_BYTE;
            end else begin
               result.frame_event = (bcrc_next == 16'd0) ? EV_GOOD : EV_BAD;
               header_count_in    = 2'd0;
               frame_length_in    = 7'd0;
               body_count_in      = 8'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= 2'd0;
         frame_length_ff <= 7'd0;
         body_count_ff   <= 8'd0;
      end else if (step) begin
         header_count_ff <= header_count_in;
         frame_length_ff <= frame_length_in;
         body_count_ff   <= body_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         header_crc_ff <= header_crc_in;
         body_crc_ff   <= body_crc_in;
      end
   end

endmodule

/* src/crc_framed_packet_deframer.sv */
// ---------------------------------------------------------------------------
// crc_framed_packet_deframer
// Byte-stream deframer: sync / length / CRC-8 header, CRC-16 trailer, one
// event per received byte.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_rx_byte
//   rsp      out        rsp_valid / rsp_stall   rsp_frame_event, rsp_data_byte,
//                                               rsp_payload_index,
//                                               rsp_payload_length
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// one byte per cycle sustained while rsp_stall is low; an accepted byte passes
// through the input register and then the result register before rsp_valid rises
// the bytewise crc update sits between the input and result registers
// synchronous reset clears frame state and loads register defaults
// rsp_stall holds the result register; req_stall rises only when both
// the input and result registers are full and rsp_stall is high
// ---------------------------------------------------------------------------
module crc_framed_packet_deframer import dfr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_frame_event,
   output logic [7:0]                 rsp_data_byte,
   output logic [7:0]                 rsp_payload_index,
   output logic [6:0]                 rsp_payload_length,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg;
   result_type core_result;
   result_type result_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;
   logic       core_step;
   logic       req_take;

   dfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dfr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (core_step),
      .rx_byte (in_byte_ff),
      .result  (core_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign core_step = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (core_step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (core_step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (core_step) begin
         result_ff <= core_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_event    = result_ff.frame_event;
   assign rsp_data_byte      = result_ff.data_byte;
   assign rsp_payload_index  = result_ff.payload_index;
   assign rsp_payload_length = result_ff.payload_length;

endmodule

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed packet deframer. Byte streams of good,
// corrupted, truncated and malformed frames mixed with line noise go in
// under random valid and stall gaps. A scoreboard tracks the frame state,
// predicts the event for every accepted byte and compares it field by field
// with each result transaction. Register settings change between phases,
// including all-zero and all-one extremes.
// ---------------------------------------------------------------------------
module tb_top import dfr_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int REPORT_LIMIT   = 10;
   localparam int IDLE_PERCENT   = 22;
   localparam int PHASE_BYTES    = 120;
   localparam int CSR_INDEX_LAST = (1 << CSR_INDEX_WIDTH) - 1;
   localparam int CFG_BITS       = $bits(cfg_type);

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_TRAILER,
      FRAME_BAD_LENGTH,
      FRAME_BAD_HEADER,
      FRAME_CUT_SHORT
   } frame_kind_type;

   class deframe_scoreboard_type;
      cfg_type     cfg;
      logic [1:0]  hdr_count;
      logic [6:0]  frame_len;
      logic [7:0]  body_count;
      logic [7:0]  hdr_crc;
      logic [15:0] body_crc;
      result_type  pending_events[$];
      int          mismatches;

      function new();
         cfg.sync_value      = SYNC_VALUE_RESET;
         cfg.header_crc_poly = HEADER_CRC_POLY_RESET;
         cfg.header_crc_seed = HEADER_CRC_SEED_RESET;
         cfg.body_crc_poly   = BODY_CRC_POLY_RESET;
         cfg.body_crc_seed   = BODY_CRC_SEED_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         hdr_count  = '0;
         frame_len  = '0;
         body_count = '0;
         hdr_crc    = cfg.header_crc_seed;
         body_crc   = cfg.body_crc_seed;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SYNC_VALUE:      cfg.sync_value      = data[7:0];
            CSR_HEADER_CRC_POLY: cfg.header_crc_poly = data[7:0];
            CSR_HEADER_CRC_SEED: cfg.header_crc_seed = data[7:0];
            CSR_BODY_CRC_POLY:   cfg.body_crc_poly   = data;
            CSR_BODY_CRC_SEED:   cfg.body_crc_seed   = data;
            default: ;
         endcase
      endfunction

      // bit-serial msb-first updates
      function logic [7:0] crc8_step(logic [7:0] r, logic [7:0] d);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? cfg.header_crc_poly : 8'h00);
         end
         return r;
      endfunction

      function logic [15:0] crc16_step(logic [15:0] r, logic [7:0] d);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0} ^ (fb ? cfg.body_crc_poly : 16'h0000);
         end
         return r;
      endfunction

      function void note_byte(logic [7:0] b);
         result_type ev;
         int idx;
         int len;
         ev = '0;
         ev.frame_event = EV_DISCARD;
         ev.data_byte   = b;
         case (hdr_count)
            2'd0: begin
               if (b == cfg.sync_value) begin
                  hdr_crc   = crc8_step(cfg.header_crc_seed, b);
                  hdr_count = 2'd1;
                  ev.frame_event = EV_HEADER;
               end
            end
            2'd1: begin
               if (b[7]) begin
                  restart();
                  ev.frame_event = EV_BAD_LEN;
               end else begin
                  hdr_crc   = crc8_step(hdr_crc, b);
                  frame_len = b[6:0];
                  hdr_count = 2'd2;
                  ev.frame_event = EV_HEADER;
               end
            end
            2'd2: begin
               hdr_crc = crc8_step(hdr_crc, b);
               if (hdr_crc != 8'h00) begin
                  restart();
                  ev.frame_event = EV_BAD_HCRC;
               end else begin
                  hdr_count  = HDR_IN_BODY;
                  body_count = '0;
                  body_crc   = cfg.body_crc_seed;
                  ev.frame_event = EV_HEADER;
               end
            end
            default: begin
               idx = int'(body_count);
               len = int'(frame_len);
               ev.payload_index  = body_count;
               ev.payload_length = frame_len;
               body_crc   = crc16_step(body_crc, b);
               body_count = body_count + 8'd1;
               if (idx < len) begin
                  ev.frame_event = EV_PAYLOAD;
               end else if (idx == len) begin
                  ev.frame_event = EV_CRC_BYTE;
               end else begin
                  ev.frame_event = (body_crc == 16'h0000) ? EV_GOOD : EV_BAD;
                  restart();
               end
            end
         endcase
         pending_events.push_back(ev);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result transaction: event %0d byte %02h",
                        got.frame_event, got.data_byte);
            return;
         end
         want = pending_events.pop_front();
         if (got.frame_event !== want.frame_event || got.data_byte !== want.data_byte ||
             got.payload_index !== want.payload_index ||
             got.payload_length !== want.payload_length) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: expected ev %0d byte %02h idx %0d len %0d, %s %0d %02h %0d %0d",
                        want.frame_event, want.data_byte, want.payload_index,
                        want.payload_length, "got", got.frame_event, got.data_byte,
                        got.payload_index, got.payload_length);
         end
      endfunction

      function int pending();
         return pending_events.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [2:0]                 rsp_frame_event;
   logic [7:0]                 rsp_data_byte;
   logic [7:0]                 rsp_payload_index;
   logic [6:0]                 rsp_payload_length;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   deframe_scoreboard_type sb;
   bit steady_flow = 1'b0;
   int frame_bytes_sent = 0;
   int cycle_count = 0;

   crc_framed_packet_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_event    (rsp_frame_event),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_payload_length (rsp_payload_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stalls, check every accepted transaction
   always @(posedge clock) begin
      result_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.frame_event    = frame_event_type'(rsp_frame_event);
         got.data_byte      = rsp_data_byte;
         got.payload_index  = rsp_payload_index;
         got.payload_length = rsp_payload_length;
         sb.check_result(got);
      end
      rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   task automatic send_frame(input frame_kind_type kind, input int len);
      logic [7:0]  frame_q[$];
      logic [7:0]  hcrc;
      logic [15:0] bcrc;
      int          i;
      int          pos;
      hcrc = sb.crc8_step(sb.crc8_step(sb.cfg.header_crc_seed, sb.cfg.sync_value), 8'(len));
      frame_q.push_back(sb.cfg.sync_value);
      if (kind == FRAME_BAD_LENGTH) begin
         frame_q.push_back({1'b1, 7'($urandom)});
      end else begin
         frame_q.push_back(8'(len));
         if (kind == FRAME_BAD_HEADER) begin
            frame_q.push_back(hcrc ^ 8'($urandom_range(255, 1)));
         end else begin
            frame_q.push_back(hcrc);
            bcrc = sb.cfg.body_crc_seed;
            for (i = 0; i < len; i++) begin
               frame_q.push_back(8'($urandom));
               bcrc = sb.crc16_step(bcrc, frame_q[frame_q.size()-1]);
            end
            frame_q.push_back(bcrc[15:8]);
            frame_q.push_back(bcrc[7:0]);
            if (kind == FRAME_BAD_TRAILER) begin
               pos = $urandom_range(frame_q.size() - 1, 3);
               frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(7));
            end
            if (kind == FRAME_CUT_SHORT)
               repeat ($urandom_range(len + 2, 1)) void'(frame_q.pop_back());
         end
      end
      foreach (frame_q[k]) send_byte(frame_q[k]);
      frame_bytes_sent += frame_q.size();
   endtask

   function automatic int pick_length();
      if ($urandom_range(99) < 3) return 127;
      return $urandom_range(15);
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(input cfg_type c);
      int i;
      wait_drained();
      write_csr(CSR_SYNC_VALUE,      {8'h00, c.sync_value});
      write_csr(CSR_HEADER_CRC_POLY, {8'h00, c.header_crc_poly});
      write_csr(CSR_HEADER_CRC_SEED, {8'h00, c.header_crc_seed});
      write_csr(CSR_BODY_CRC_POLY,   c.body_crc_poly);
      write_csr(CSR_BODY_CRC_SEED,   c.body_crc_seed);
      // unused indexes must leave the settings alone
      for (i = int'(CSR_BODY_CRC_SEED) + 1; i <= CSR_INDEX_LAST; i++)
         write_csr(CSR_INDEX_WIDTH'(i), 16'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int budget, input bit pause_midway);
      int stop_at;
      int pick;
      stop_at = frame_bytes_sent + budget;
      while (frame_bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60)      send_frame(FRAME_GOOD, pick_length());
         else if (pick < 72) send_frame(FRAME_BAD_TRAILER, pick_length());
         else if (pick < 80) send_frame(FRAME_BAD_LENGTH, 0);
         else if (pick < 88) send_frame(FRAME_BAD_HEADER, pick_length());
         else if (pick < 93) send_frame(FRAME_CUT_SHORT, pick_length());
         else                send_noise($urandom_range(4, 1));
         if (pause_midway && frame_bytes_sent >= stop_at - budget / 2) begin
            wait_drained();
            pause_midway = 1'b0;
         end
      end
      // leave some phases mid-frame so settings change under an open frame
      if ($urandom_range(1) == 0) send_frame(FRAME_CUT_SHORT, pick_length());
   endtask

   initial begin
      cfg_type c;
      int phase;
      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_rx_byte      <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(FRAME_GOOD, 0);
      send_frame(FRAME_BAD_LENGTH, 0);
      send_frame(FRAME_BAD_HEADER, 127);
      send_frame(FRAME_GOOD, 1);
      send_frame(FRAME_BAD_TRAILER, 2);

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: c = '0;
            1: c = '1;
            2: c = '{8'h7E, 8'h07, 8'h00, 16'h1021, 16'hFFFF};
            default: c = cfg_type'(CFG_BITS'({$urandom, $urandom}));
         endcase
         configure(c);
         steady_flow <= (phase == 3);
         run_random(PHASE_BYTES, phase == 5);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
